@@ hdl/vdi_pkg.sv @@
package vdi_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int COORD_W             = 32;
    localparam int INDEX_W             = 6;

    // One vertex as three float32 bit patterns, x in the lowest bits.
    typedef struct packed {
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_vertex;

    localparam int VERTEX_W = $bits(t_vertex);

endpackage

@@ hdl/vertex_dedup_indexer_top.sv @@
// Vertex deduplication table: one result word per input word.
// Each word is compared with the stored entries in order until the first match (all
// entries on a miss), through the single read port of the vertex store, which is
// scanned one entry per cycle. One vertex at a time: no new word is taken until the
// previous result has moved into the output register.
// Reset (synchronous, active low) empties the table and the output register.
module vertex_dedup_indexer_top
    import vdi_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [VERTEX_W-1:0] i_s_tdata,   // vertex_x, vertex_y, vertex_z
    input  logic                i_s_tuser,   // new_mesh
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [7:0]          o_m_tdata,   // unique_index, two zero bits
    output logic [1:0]          o_m_tuser    // first_seen, overflow
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               first_seen;
        logic               overflow;
    } t_result;

    t_state              r_state;
    t_vertex             r_vertex;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_rd_ptr;
    logic                r_pend;
    logic [IDX_W-1:0]    r_pend_idx;
    t_vertex             r_rd_data;
    t_result             r_res;
    t_result             r_out;
    logic                r_out_vld;

    t_vertex             r_mem [TABLE_DEPTH];

    logic                s_accept;
    logic                hit;
    logic                last_entry;
    logic                found;
    logic                miss;
    logic                full;
    logic                rd_en;
    logic                wr_en;
    logic                out_free;
    t_result             n_res;

    vdi_match u_match (
        .i_stored (r_rd_data),
        .i_probe  (r_vertex),
        .o_hit    (hit)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_vld || i_m_tready;

    assign full       = (r_count == CNT_W'(TABLE_DEPTH));
    assign last_entry = (CNT_W'(r_pend_idx) + CNT_W'(1)) == r_count;
    assign found      = (r_state == S_SCAN) && r_pend && hit;
    // With an empty table the first scan cycle has nothing pending and decides at once.
    assign miss       = (r_state == S_SCAN)
                     && (r_pend ? (last_entry && !hit) : (r_rd_ptr == r_count));
    assign rd_en      = (r_state == S_SCAN) && !found && !miss && (r_rd_ptr < r_count);
    assign wr_en      = miss && !full;

    always_comb begin
        n_res = '0;
        if (found) begin
            n_res.index = INDEX_W'(r_pend_idx);
        end else if (full) begin
            n_res.overflow = 1'b1;
        end else begin
            n_res.index      = INDEX_W'(r_count);
            n_res.first_seen = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= r_vertex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_ptr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_vertex <= t_vertex'(i_s_tdata);
        end
        if (rd_en) begin
            r_pend_idx <= r_rd_ptr[IDX_W-1:0];
        end
        if (found || miss) begin
            r_res <= n_res;
        end
        if (r_state == S_OUT && out_free) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_ptr  <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_pend <= rd_en;
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + CNT_W'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_rd_ptr <= '0;
                        if (i_s_tuser) begin
                            r_count <= '0;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (found || miss) begin
                        if (wr_en) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_OUT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(8 - INDEX_W){1'b0}}, r_out.index};
    assign o_m_tuser  = {r_out.overflow, r_out.first_seen};

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_overflow_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && r_res.overflow |-> full && !r_res.first_seen)
        else $error("overflow reported while the table has room");

    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCAN))
        else $error("store read pending outside the scan");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_SCAN) && !r_pend)
        else $error("accepted word did not start a scan");

endmodule

@@ hdl/vdi_match.sv @@
module vdi_match
    import vdi_pkg::*;
(
    input  t_vertex i_stored,
    input  t_vertex i_probe,
    output logic    o_hit
);

    function automatic logic coord_is_nan(input logic [COORD_W-1:0] b);
        return b[COORD_W-2:0] > 31'h7F80_0000;
    endfunction

    // IEEE equality: both zeros match regardless of sign, NaN matches nothing.
    function automatic logic coord_equal(input logic [COORD_W-1:0] a,
                                         input logic [COORD_W-1:0] b);
        logic any_nan;
        logic both_zero;
        any_nan   = coord_is_nan(a) || coord_is_nan(b);
        both_zero = ((a | b) & 32'h7FFF_FFFF) == 32'h0;
        return !any_nan && (both_zero || (a == b));
    endfunction

    assign o_hit = coord_equal(i_stored.x, i_probe.x)
                && coord_equal(i_stored.y, i_probe.y)
                && coord_equal(i_stored.z, i_probe.z);

endmodule

@@ sim/vertex_dedup_indexer_top_tb.sv @@
`timescale 1ns / 1ps

module vertex_dedup_indexer_top_tb;

    import vdi_pkg::*;

    localparam int TB_DEPTH     = DEFAULT_TABLE_DEPTH;
    localparam int DRAIN_CYCLES = TB_DEPTH + 20;

    typedef struct {
        logic [INDEX_W-1:0] unique_index;
        logic               first_seen;
        logic               overflow;
    } t_lookup_result;

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [VERTEX_W-1:0] i_s_tdata  = '0;   // vertex_x, vertex_y, vertex_z
    logic                i_s_tuser  = 1'b0; // new_mesh
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [7:0]          o_m_tdata;         // unique_index, two zero bits
    logic [1:0]          o_m_tuser;         // first_seen, overflow

    vertex_dedup_indexer_top #(
        .TABLE_DEPTH (TB_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Shadow copy of the unique vertex table.
    t_vertex unique_table [TB_DEPTH];
    int      unique_count = 0;

    t_lookup_result pending_lookups[$];

    bit idle_en      = 1'b1;
    bit hold_request = 1'b0;
    int hold_cycles  = 0;
    int fail_count   = 0;
    int words_sent   = 0;
    int hit_count    = 0;
    int append_count = 0;
    int ovf_count    = 0;
    int mesh_count   = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit coord_is_nan(logic [COORD_W-1:0] c);
        return c[30:0] > 31'h7F80_0000;
    endfunction

    // IEEE equality on raw bit patterns: signed zeros match, NaN never does.
    function automatic bit coord_equal(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
        logic [COORD_W-1:0] both;
        both = a | b;
        if (coord_is_nan(a) || coord_is_nan(b))
            return 1'b0;
        if (both[30:0] == '0)
            return 1'b1;
        return a == b;
    endfunction

    function automatic t_lookup_result dedup_lookup(bit new_mesh, t_vertex v);
        t_lookup_result r;
        if (new_mesh)
            unique_count = 0;
        for (int k = 0; k < unique_count; k++) begin
            if (coord_equal(unique_table[k].x, v.x) && coord_equal(unique_table[k].y, v.y) &&
                coord_equal(unique_table[k].z, v.z)) begin
                r.unique_index = k[INDEX_W-1:0];
                r.first_seen   = 1'b0;
                r.overflow     = 1'b0;
                return r;
            end
        end
        if (unique_count >= TB_DEPTH) begin
            r.unique_index = '0;
            r.first_seen   = 1'b0;
            r.overflow     = 1'b1;
            return r;
        end
        unique_table[unique_count] = v;
        r.unique_index = unique_count[INDEX_W-1:0];
        r.first_seen   = 1'b1;
        r.overflow     = 1'b0;
        unique_count++;
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the word is accepted.
    task automatic send_vertex(input bit new_mesh, input t_vertex v);
        t_lookup_result r;
        if (idle_en && $urandom_range(99) < 24) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 70)) @(posedge i_clk);
        end
        i_s_tdata  <= v;
        i_s_tuser  <= new_mesh;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        r = dedup_lookup(new_mesh, v);
        pending_lookups = {pending_lookups, r};
        words_sent++;
        if (new_mesh)
            mesh_count++;
        if (r.overflow)
            ovf_count++;
        else if (r.first_seen)
            append_count++;
        else
            hit_count++;
    endtask

    function automatic t_vertex make_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_vertex v;
        v.x = x;
        v.y = y;
        v.z = z;
        return v;
    endfunction

    // Coordinates lean toward zeros, infinities, NaNs and a small grid so that
    // partial matches between vertices are common.
    function automatic logic [COORD_W-1:0] random_coord();
        logic [COORD_W-1:0] c;
        case ($urandom_range(9))
            0: c = 32'h0000_0000;
            1: c = 32'h8000_0000;
            2: c = {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
            3: c = {1'($urandom_range(1)), 8'hFF, 23'h0};
            4: c = 32'hFFFF_FFFF;
            5, 6: c = 32'h3F80_0000 + ($urandom_range(3) << 21);
            default: c = $urandom;
        endcase
        return c;
    endfunction

    function automatic logic [COORD_W-1:0] flip_zero_sign(logic [COORD_W-1:0] c);
        if (c[30:0] == '0 && $urandom_range(1))
            return c ^ 32'h8000_0000;
        return c;
    endfunction

    // Meshes of repeated corners, mostly small; a few grow past the table size.
    task automatic run_meshes(input int n_words);
        t_vertex pool[$];
        t_vertex v;
        int      sent;
        int      mesh_len;
        int      reuse_pct;
        bit      start;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(7) == 0) begin
                mesh_len  = $urandom_range(90, 170);
                reuse_pct = 30;
            end else begin
                mesh_len  = $urandom_range(4, 60);
                reuse_pct = 60;
            end
            pool.delete();
            for (int i = 0; i < mesh_len && sent < n_words; i++) begin
                start = (i == 0) || ($urandom_range(99) < 3);
                if (start && i != 0)
                    pool.delete();
                if (pool.size() != 0 && $urandom_range(99) < reuse_pct) begin
                    v = pool[$urandom_range(pool.size() - 1)];
                    v.x = flip_zero_sign(v.x);
                    v.y = flip_zero_sign(v.y);
                    v.z = flip_zero_sign(v.z);
                end else begin
                    v = make_vertex(random_coord(), random_coord(), random_coord());
                    pool = {pool, v};
                end
                send_vertex(start, v);
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        send_vertex(1'b1, make_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_vertex(1'b0, make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_vertex(1'b0, make_vertex(32'h8000_0000, 32'h0000_0000, 32'h0000_0000));
        send_vertex(1'b0, make_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_vertex(1'b0, make_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_vertex(1'b0, make_vertex(32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF));
        send_vertex(1'b0, make_vertex(32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF));
        send_vertex(1'b0, make_vertex(32'h7FC0_0000, 32'h0000_0000, 32'h0000_0000));
        send_vertex(1'b0, make_vertex(32'h3F80_0000, 32'h0000_0000, 32'h0000_0000));
        send_vertex(1'b0, make_vertex(32'h0000_0000, 32'h3F80_0000, 32'h0000_0000));
        send_vertex(1'b0, make_vertex(32'h3F80_0000, 32'h0000_0000, 32'h8000_0000));
        // Denormals are ordinary values: the sign bit matters for them.
        send_vertex(1'b0, make_vertex(32'h0000_0001, 32'h0000_0000, 32'h0000_0000));
        send_vertex(1'b0, make_vertex(32'h8000_0001, 32'h0000_0000, 32'h0000_0000));
        send_vertex(1'b0, make_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678));
        send_vertex(1'b0, make_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678));
        send_vertex(1'b0, make_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'hEDCB_A987));
        send_vertex(1'b1, make_vertex(32'h3F80_0000, 32'h0000_0000, 32'h0000_0000));
        send_vertex(1'b0, make_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_vertex(1'b1, make_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_vertex(1'b1, make_vertex(32'h8000_0000, 32'h0000_0000, 32'h8000_0000));
        send_vertex(1'b0, make_vertex(32'h0000_0000, 32'h8000_0000, 32'h0000_0000));
    endtask

    // Fill every entry, then probe the full table with misses, hits and a NaN.
    task automatic test_table_overflow();
        for (int k = 0; k < TB_DEPTH; k++)
            send_vertex(k == 0, make_vertex(32'h4000_0000 + k, ~k, 32'h0000_0000));
        send_vertex(1'b0, make_vertex(32'h4000_1000, 32'h0, 32'h0));
        send_vertex(1'b0, make_vertex(32'h4000_0000 + TB_DEPTH - 1, ~(TB_DEPTH - 1),
                                      32'h8000_0000));
        send_vertex(1'b0, make_vertex(32'h4000_0000, 32'hFFFF_FFFF, 32'h0));
        send_vertex(1'b0, make_vertex(32'h7FC0_0001, 32'h0, 32'h0));
        send_vertex(1'b1, make_vertex(32'h4000_1000, 32'h0, 32'h0));
    endtask

    task automatic test_no_idle();
        idle_en = 1'b0;
        run_meshes(200);
        idle_en = 1'b1;
    endtask

    // The receiver stops for a long stretch while words keep coming, so the
    // block fills up and must stall its input.
    task automatic test_output_hold();
        hold_cycles  = 400;
        hold_request = 1'b1;
        run_meshes(12);
    endtask

    task automatic test_random();
        run_meshes(1250);
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                i_m_tready <= !idle_en || ($urandom_range(99) >= 24);
            end
        end
    end

    always @(posedge i_clk) begin
        t_lookup_result exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_lookups.size() == 0) begin
                $error("unexpected result word: tdata %h tuser %b", o_m_tdata, o_m_tuser);
                fail_count++;
            end else begin
                exp_r = pending_lookups.pop_front();
                if (o_m_tdata[INDEX_W-1:0] !== exp_r.unique_index) begin
                    $error("unique_index: expected %0d, got %0d", exp_r.unique_index,
                           o_m_tdata[INDEX_W-1:0]);
                    fail_count++;
                end
                if (o_m_tuser[0] !== exp_r.first_seen) begin
                    $error("first_seen: expected %0d, got %0d", exp_r.first_seen,
                           o_m_tuser[0]);
                    fail_count++;
                end
                if (o_m_tuser[1] !== exp_r.overflow) begin
                    $error("overflow: expected %0d, got %0d", exp_r.overflow, o_m_tuser[1]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_table_overflow();
        test_no_idle();
        test_output_hold();
        test_random();
        @(posedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d vertices over %0d meshes: %0d appended, %0d matched, %0d overflowed.",
                 words_sent, mesh_count, append_count, hit_count, ovf_count);
        $display("Phases: directed corners, full table, back-to-back, output hold, random.");
        if (fail_count == 0) begin
            $display("[vertex_dedup_indexer_top] OK");
        end else begin
            $display("[vertex_dedup_indexer_top] ERROR");
        end
        $finish;
    end

    initial begin
        #25_000_000;
        $display("Timed out with %0d results outstanding.", pending_lookups.size());
        $display("[vertex_dedup_indexer_top] ERROR");
        $finish;
    end

endmodule
